// ----- rtl/bfd_pkg.sv -----
// Shared types for the buffer frame directory: request, result and the
// token word that walks the frame cell chain. No dependencies.
`default_nettype none
package bfd_pkg;
  localparam int IDX_W     = 6;
  localparam int PAGE_BITS = 32;
  localparam int FILE_BITS = 16;
  localparam int PIN_BITS  = 16;
  localparam int FRAMES_DEF = 64;

  typedef enum logic [2:0] {
    CMD_RESERVE = 3'd0,
    CMD_LOOKUP  = 3'd1,
    CMD_REG     = 3'd2,
    CMD_UNREG   = 3'd3,
    CMD_PIN     = 3'd4,
    CMD_UNPIN   = 3'd5,
    CMD_VICTIM  = 3'd6,
    CMD_DIRTY   = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [IDX_W-1:0]     frame_sel;
    logic [PAGE_BITS-1:0] page_num;
    logic [FILE_BITS-1:0] file_num;
    logic                 dirty_in;
  } in_t;

  typedef struct packed {
    logic                found;
    logic [IDX_W-1:0]    frame_out;
    logic                is_pinned;
    logic                is_evictable;
    logic [PIN_BITS-1:0] pins;
    logic                victim_dirty;
  } out_t;

  // Request plus running search result, handed cell to cell.
  typedef struct packed {
    logic                 vld;
    cmd_t                 cmd;
    logic [IDX_W-1:0]     sel;
    logic [PAGE_BITS-1:0] page;
    logic [FILE_BITS-1:0] file;
    logic                 dirty;
    logic [IDX_W-1:0]     ptr;
    logic                 found;
    logic [IDX_W-1:0]     idx;
    logic [PIN_BITS-1:0]  pins;
    logic                 res;
    logic                 c_hi_f;
    logic [IDX_W-1:0]     c_hi_idx;
    logic                 c_lo_f;
    logic [IDX_W-1:0]     c_lo_idx;
    logic                 d_hi_f;
    logic [IDX_W-1:0]     d_hi_idx;
    logic                 d_lo_f;
    logic [IDX_W-1:0]     d_lo_idx;
  } tok_t;
endpackage
`default_nettype wire

// ----- rtl/bfd_cell.sv -----
// One frame cell: holds the state of one frame, applies the passing request
// and forwards the updated token. Depends on bfd_pkg.
`default_nettype none
module bfd_cell #(
  parameter int IDX = 0
) (
  input  wire          clk,
  input  wire          rst_n,
  input  bfd_pkg::tok_t tok_in,
  output bfd_pkg::tok_t tok_out
);
  localparam logic [bfd_pkg::IDX_W-1:0] ME = bfd_pkg::IDX_W'(IDX);
  localparam logic [bfd_pkg::PIN_BITS-1:0] PIN_MAX = '1;

  logic                          free_r, free_nxt;
  logic                          res_r, res_nxt;
  logic                          dirty_r, dirty_nxt;
  logic [bfd_pkg::PIN_BITS-1:0]  pins_r, pins_nxt;
  logic [bfd_pkg::PAGE_BITS-1:0] page_r, page_nxt;
  logic [bfd_pkg::FILE_BITS-1:0] file_r, file_nxt;
  bfd_pkg::tok_t                 tok_r, tok_nxt;
  logic                          hit, hi, cand;

  always_comb begin
    free_nxt  = free_r;
    res_nxt   = res_r;
    dirty_nxt = dirty_r;
    pins_nxt  = pins_r;
    page_nxt  = page_r;
    file_nxt  = file_r;
    tok_nxt   = tok_in;
    hit  = tok_in.sel == ME;
    hi   = ME >= tok_in.ptr;
    cand = res_r && (pins_r == '0);
    if (tok_in.vld) begin
      unique case (tok_in.cmd)
        bfd_pkg::CMD_RESERVE: begin
          if (!tok_in.found && free_r) begin
            free_nxt      = 1'b0;
            tok_nxt.found = 1'b1;
            tok_nxt.idx   = ME;
            tok_nxt.pins  = pins_r;
            tok_nxt.res   = res_r;
          end
        end
        bfd_pkg::CMD_LOOKUP: begin
          if (!tok_in.found && res_r && page_r == tok_in.page && file_r == tok_in.file) begin
            tok_nxt.found = 1'b1;
            tok_nxt.idx   = ME;
            tok_nxt.pins  = pins_r;
            tok_nxt.res   = res_r;
          end
        end
        bfd_pkg::CMD_REG: begin
          if (hit) begin
            page_nxt     = tok_in.page;
            file_nxt     = tok_in.file;
            pins_nxt     = '0;
            dirty_nxt    = tok_in.dirty;
            res_nxt      = 1'b1;
            tok_nxt.pins = '0;
            tok_nxt.res  = 1'b1;
          end
        end
        bfd_pkg::CMD_UNREG: begin
          if (hit) begin
            res_nxt      = 1'b0;
            pins_nxt     = '0;
            dirty_nxt    = 1'b0;
            free_nxt     = 1'b1;
            tok_nxt.pins = '0;
            tok_nxt.res  = 1'b0;
          end
        end
        bfd_pkg::CMD_PIN: begin
          if (hit) begin
            if (pins_r != PIN_MAX) pins_nxt = pins_r + 1'b1;
            tok_nxt.pins = pins_nxt;
            tok_nxt.res  = res_r;
          end
        end
        bfd_pkg::CMD_UNPIN: begin
          if (hit) begin
            if (pins_r != '0) pins_nxt = pins_r - 1'b1;
            tok_nxt.pins = pins_nxt;
            tok_nxt.res  = res_r;
          end
        end
        bfd_pkg::CMD_VICTIM: begin
          // Track first clean and first dirty candidate on each side of the pointer.
          if (cand) begin
            if (dirty_r) begin
              if (hi && !tok_in.d_hi_f) begin
                tok_nxt.d_hi_f = 1'b1; tok_nxt.d_hi_idx = ME;
              end
              if (!hi && !tok_in.d_lo_f) begin
                tok_nxt.d_lo_f = 1'b1; tok_nxt.d_lo_idx = ME;
              end
            end else begin
              if (hi && !tok_in.c_hi_f) begin
                tok_nxt.c_hi_f = 1'b1; tok_nxt.c_hi_idx = ME;
              end
              if (!hi && !tok_in.c_lo_f) begin
                tok_nxt.c_lo_f = 1'b1; tok_nxt.c_lo_idx = ME;
              end
            end
          end
        end
        bfd_pkg::CMD_DIRTY: begin
          if (hit) begin
            if (res_r) dirty_nxt = tok_in.dirty;
            tok_nxt.pins = pins_r;
            tok_nxt.res  = res_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= 1'b1;
      res_r   <= 1'b0;
      dirty_r <= 1'b0;
      pins_r  <= '0;
      tok_r   <= '0;
    end else begin
      free_r  <= free_nxt;
      res_r   <= res_nxt;
      dirty_r <= dirty_nxt;
      pins_r  <= pins_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    file_r <= file_nxt;
  end

  assign tok_out = tok_r;
endmodule
`default_nettype wire

// ----- rtl/buffer_frame_directory_top.sv -----
// Buffer frame directory top: a chain of frame cells walked by one request.
// Depends on bfd_pkg and bfd_cell.
//
// Usage:
//   Raise start with a request on in_req; it is taken when busy is low.
//   busy stays high until the result appears on out_res with out_valid
//   high for exactly one cycle. The receiver cannot stall the result.
//   The request token is registered first, then moves through one frame
//   cell per cycle, and the result is then formed and registered.
//   Every command walks the whole chain.
//   busy drops in the cycle out_valid is high, so the next request may be
//   taken at the edge that ends that cycle.
//   Reset: all frames free, none resident, pin counts and dirty flags zero,
//   victim pointer zero. Page and file keys of a frame are undefined until
//   the frame is registered.
`default_nettype none
module buffer_frame_directory_top #(
  parameter int FRAMES = bfd_pkg::FRAMES_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  output logic          busy,
  input  bfd_pkg::in_t  in_req,
  output logic          out_valid,
  output bfd_pkg::out_t out_res
);
  localparam logic [bfd_pkg::IDX_W-1:0] LAST = bfd_pkg::IDX_W'(FRAMES - 1);

  bfd_pkg::tok_t               chain [FRAMES+1];
  bfd_pkg::tok_t               tok0_r, tok0_nxt;
  logic                        busy_r, busy_nxt;
  logic                        ov_r;
  bfd_pkg::out_t               res_r, res_nxt;
  logic [bfd_pkg::IDX_W-1:0]   ptr_r, ptr_nxt;
  bfd_pkg::tok_t               t;
  logic                        accept;

  assign accept = start && !busy_r;

  always_comb begin
    tok0_nxt          = '0;
    tok0_nxt.vld      = accept;
    tok0_nxt.cmd      = bfd_pkg::cmd_t'(in_req.cmd);
    tok0_nxt.sel      = in_req.frame_sel;
    tok0_nxt.page     = in_req.page_num;
    tok0_nxt.file     = in_req.file_num;
    tok0_nxt.dirty    = in_req.dirty_in;
    tok0_nxt.ptr      = ptr_r;
  end

  assign chain[0] = tok0_r;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    bfd_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_in (chain[g]),
      .tok_out(chain[g+1])
    );
  end

  assign t = chain[FRAMES];

  always_comb begin
    res_nxt           = '0;
    res_nxt.frame_out = t.sel;
    ptr_nxt           = ptr_r;
    busy_nxt          = busy_r;
    if (accept) busy_nxt = 1'b1;
    if (t.vld) busy_nxt = 1'b0;
    unique case (t.cmd)
      bfd_pkg::CMD_RESERVE, bfd_pkg::CMD_LOOKUP: begin
        if (t.found) begin
          res_nxt.found        = 1'b1;
          res_nxt.frame_out    = t.idx;
          res_nxt.pins         = t.pins;
          res_nxt.is_pinned    = t.pins != '0;
          res_nxt.is_evictable = t.res && (t.pins == '0);
        end
      end
      bfd_pkg::CMD_VICTIM: begin
        // Clean at or after the pointer, clean before it, then the same for dirty.
        if (t.c_hi_f || t.c_lo_f || t.d_hi_f || t.d_lo_f) begin
          res_nxt.found        = 1'b1;
          res_nxt.is_evictable = 1'b1;
          if (t.c_hi_f) res_nxt.frame_out = t.c_hi_idx;
          else if (t.c_lo_f) res_nxt.frame_out = t.c_lo_idx;
          else begin
            res_nxt.victim_dirty = 1'b1;
            res_nxt.frame_out    = t.d_hi_f ? t.d_hi_idx : t.d_lo_idx;
          end
          if (t.vld) begin
            ptr_nxt = (res_nxt.frame_out == LAST) ? '0 : res_nxt.frame_out + 1'b1;
          end
        end
      end
      default: begin
        res_nxt.pins         = t.pins;
        res_nxt.is_pinned    = t.pins != '0;
        res_nxt.is_evictable = t.res && (t.pins == '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      ptr_r  <= '0;
      tok0_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= t.vld;
      ptr_r  <= ptr_nxt;
      tok0_r <= tok0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = ov_r;
  assign out_res   = res_r;
endmodule
`default_nettype wire

// ----- rtl/bfd_checker.sv -----
// Port-level checks for the buffer frame directory top, bound to it below.
// Depends on bfd_pkg and buffer_frame_directory_top.
`default_nettype none
module bfd_checker (
  input wire           clk,
  input wire           rst_n,
  input wire           start,
  input wire           busy,
  input wire           out_valid,
  input bfd_pkg::out_t out_res
);
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request taken but busy low");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while still busy");
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_fell_res: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy dropped without result");
  a_vd_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.victim_dirty |-> out_res.found)
    else $error("victim dirty without a frame");
endmodule

bind buffer_frame_directory_top bfd_checker u_bfd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_res  (out_res)
);
`default_nettype wire
